/* design/lmfs_pkg.sv */
// Shared types, constants and helpers for the LED matrix frame store serializer.
// No dependencies; used by lmfs_store and the top level.
package lmfs_pkg;

    localparam int DEVICES  = 4;                 // drivers in the chain, 1..8
    localparam int ROWS     = 8;
    localparam int ROW_W    = 3;
    localparam int DEV_W    = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int DEPTH    = ROWS * DEVICES;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PAT_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int DIGIT_W  = 4;

    localparam logic [DEV_W-1:0] DEV_LAST = DEV_W'(DEVICES - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

    typedef enum logic [1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_SET_ROW = 2'd1,
        KIND_SET_COL = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } t_store_req;

    // row-major entry address: row * DEVICES + device
    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                   input logic [DEV_W-1:0] dev);
        return ADDR_W'(int'(row) * DEVICES + int'(dev));
    endfunction

    // byte d of the pattern; devices past the fourth get zero
    function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] pat,
                                                        input logic [DEV_W-1:0] dev);
        logic [BYTE_W-1:0] b;
        case (int'(dev))
            0:       b = pat[7:0];
            1:       b = pat[15:8];
            2:       b = pat[23:16];
            3:       b = pat[31:24];
            default: b = '0;
        endcase
        return b & BYTE_MASK;
    endfunction

endpackage

/* design/lmfs_store.sv */
// Frame store memory: one write port, one registered read port, per-entry valid bits.
// Depends on lmfs_pkg.
module lmfs_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lmfs_pkg::t_store_req        i_req,
    output logic [lmfs_pkg::BYTE_W-1:0] o_rd_data
);

    logic [lmfs_pkg::BYTE_W-1:0] r_mem [lmfs_pkg::DEPTH];
    logic [lmfs_pkg::DEPTH-1:0]  r_valid;
    logic [lmfs_pkg::BYTE_W-1:0] r_rd_data;

    // entries never written since reset or clear read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/led_matrix_frame_store_serializer.sv */
// Top level: command decode, row/device sequencer, byte merge unit, output register.
// Depends on lmfs_pkg and lmfs_store.
//
// Frame store and serializer for a chain of lmfs_pkg::DEVICES cascaded 8x8 LED
// matrix drivers. The store keeps 8 rows by DEVICES bytes and resets to zero.
// A command word carries kind in tuser: clear (0) zeroes the store and sends
// rows 0..7; set row (1) writes pattern byte i to device i of row_index and
// sends that row; set column (2) sets or clears bit column_index%8 of device
// column_index/8 in every row from pattern bit r, sending each row after its
// update. Kind 3, and a set column aimed past the chain, are dropped with no
// output. Each output word is one (digit register = row+1, segment byte)
// pair, devices in order from 0 up; tuser flags the last pair of a row (end
// of a chip-select frame) and tlast the last word of the command.
// Timing: the sequencer walks the store one entry per cycle through the
// store's single read port while the output is not stalled; after the accept
// a command gives one output word per entry walked, 8*DEVICES for clear and
// set column and DEVICES for set row, and a dropped command is only accepted.
// Output backpressure stalls the walk. The input is ready again once the last
// word is in the output register, even if it has not been taken yet.
module led_matrix_frame_store_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // [2:0] row_index, [7:3] column_index,
                                         // [39:8] pattern
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] kind
    // driver word stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [3:0] digit_register, [11:4] segment_byte,
                                         // [15:12] zero
    output logic [0:0]  o_m_axis_tuser,  // [0] frame_end
    output logic        o_m_axis_tlast
);

    // input fields
    logic [lmfs_pkg::ROW_W-1:0] in_row;
    logic [4:0]                 in_col;
    logic [lmfs_pkg::PAT_W-1:0] in_pattern;
    lmfs_pkg::t_kind            in_kind;
    logic                       in_accept;
    logic                       in_cmd_ok;

    assign in_row     = i_s_axis_tdata[2:0];
    assign in_col     = i_s_axis_tdata[7:3];
    assign in_pattern = i_s_axis_tdata[39:8];
    assign in_kind    = lmfs_pkg::t_kind'(i_s_axis_tuser);

    // sequencer state
    lmfs_pkg::t_state            r_state, n_state;
    lmfs_pkg::t_kind             r_kind;
    logic [lmfs_pkg::ROW_W-1:0]  r_row, n_row;
    logic [lmfs_pkg::DEV_W-1:0]  r_dev, n_dev;
    logic [lmfs_pkg::DEV_W-1:0]  r_col_dev;
    logic [2:0]                  r_col_bit;
    logic [lmfs_pkg::PAT_W-1:0]  r_pattern;

    // output register
    logic                        r_out_valid;
    logic [lmfs_pkg::DIGIT_W-1:0] r_out_digit;
    logic [lmfs_pkg::BYTE_W-1:0] r_out_byte;
    logic                        r_out_frame_end;
    logic                        r_out_last;

    lmfs_pkg::t_store_req        store_req;
    logic [lmfs_pkg::BYTE_W-1:0] rd_data;
    logic [lmfs_pkg::BYTE_W-1:0] merged;
    logic [lmfs_pkg::BYTE_W-1:0] col_mask;
    logic [7:0]                  col_pattern;
    logic                        step;
    logic                        final_step;
    logic                        on_col_dev;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // drop unused kinds and columns beyond the chain
    always_comb begin
        unique case (in_kind)
            lmfs_pkg::KIND_CLEAR,
            lmfs_pkg::KIND_SET_ROW: in_cmd_ok = 1'b1;
            lmfs_pkg::KIND_SET_COL: in_cmd_ok = (int'(in_col[4:3]) < lmfs_pkg::DEVICES);
            default:                in_cmd_ok = 1'b0;
        endcase
    end

    // one word per cycle unless the output register is still full
    assign step       = (r_state == lmfs_pkg::ST_EMIT) && (!r_out_valid || i_m_axis_tready);
    assign final_step = (r_dev == lmfs_pkg::DEV_LAST) &&
                        ((r_kind == lmfs_pkg::KIND_SET_ROW) || (r_row == lmfs_pkg::ROW_LAST));
    assign on_col_dev = (r_dev == r_col_dev);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmfs_pkg::ST_IDLE: if (in_accept && in_cmd_ok) n_state = lmfs_pkg::ST_EMIT;
            lmfs_pkg::ST_EMIT: if (step && final_step) n_state = lmfs_pkg::ST_IDLE;
            default:           n_state = lmfs_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: walk position and store requests
    always_comb begin
        n_row           = r_row;
        n_dev           = r_dev;
        store_req       = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            lmfs_pkg::ST_IDLE: begin
                // always ready here, so tvalid alone marks an accepted word
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid && in_cmd_ok) begin
                    n_row = (in_kind == lmfs_pkg::KIND_SET_ROW) ? in_row : '0;
                    n_dev = '0;
                    store_req.clear = (in_kind == lmfs_pkg::KIND_CLEAR);
                    store_req.rd_en = 1'b1;
                end
            end
            lmfs_pkg::ST_EMIT: begin
                if (step) begin
                    store_req.wr_en = (r_kind == lmfs_pkg::KIND_SET_ROW) ||
                                      ((r_kind == lmfs_pkg::KIND_SET_COL) && on_col_dev);
                    if (!final_step) begin
                        // prefetch the next entry while this word goes out
                        if (r_dev == lmfs_pkg::DEV_LAST) begin
                            n_dev = '0;
                            n_row = r_row + 1'b1;
                        end else begin
                            n_dev = r_dev + 1'b1;
                        end
                        store_req.rd_en = 1'b1;
                    end
                end
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
        store_req.rd_addr = lmfs_pkg::addr_of(n_row, n_dev);
        store_req.wr_addr = lmfs_pkg::addr_of(r_row, r_dev);
        store_req.wr_data = merged;
    end

    // byte merge unit, shared by every step
    assign col_pattern = r_pattern[7:0];
    assign col_mask    = lmfs_pkg::BYTE_W'(1) << r_col_bit;

    always_comb begin
        case (r_kind)
            lmfs_pkg::KIND_CLEAR:   merged = '0;
            lmfs_pkg::KIND_SET_ROW: merged = lmfs_pkg::pattern_byte(r_pattern, r_dev);
            lmfs_pkg::KIND_SET_COL: begin
                if (!on_col_dev) begin
                    merged = rd_data;
                end else if (col_pattern[r_row]) begin
                    merged = rd_data | col_mask;
                end else begin
                    merged = rd_data & ~col_mask;
                end
            end
            default:                merged = rd_data;
        endcase
    end

    lmfs_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmfs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command and walk registers
    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_dev <= n_dev;
        if (in_accept) begin
            r_kind    <= in_kind;
            r_col_dev <= lmfs_pkg::DEV_W'(in_col[4:3]);
            r_col_bit <= in_col[2:0];
            r_pattern <= in_pattern;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_digit     <= {1'b0, r_row} + 4'd1;
            r_out_byte      <= merged;
            r_out_frame_end <= (r_dev == lmfs_pkg::DEV_LAST);
            r_out_last      <= final_step;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {4'b0000, r_out_byte, r_out_digit};
    assign o_m_axis_tuser[0] = r_out_frame_end;
    assign o_m_axis_tlast    = r_out_last;

endmodule
